// ----- rtl/core/pvgis_pkg.sv -----
// Package for the PID step with variable proportional gain and integral separation.
// Holds widths, ramp constants, register indexes and the configuration struct.
// No dependencies.
package pvgis_pkg;

  localparam int GAIN_FRAC_BITS = 8;

  localparam int IN_W    = 16;
  localparam int ERR_W   = IN_W + 1;
  localparam int PREV_W  = 18;
  localparam int ISUM_W  = 24;
  localparam int GAIN_W  = 16;
  localparam int ILIM_W  = 23;
  localparam int DLIM_W  = 15;
  localparam int OUT_W   = 16;
  localparam int ACC_W   = 34;
  localparam int CFG_W   = 23;
  localparam int IDX_W   = 3;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int RAMP_SPAN = 300;
  localparam int RAMP_BASE = 700;
  localparam int SUM_SAT   = 30000;

  // x / 1000 / 2^F is done as (x >> (F + 3)) / 125
  localparam int RC_SHIFT  = GAIN_FRAC_BITS + 3;
  localparam int DIV_CONST = 125;
  localparam int RECIP_SH  = 22;
  localparam int RECIP     = (1 << RECIP_SH) / DIV_CONST;

  localparam logic [IDX_W-1:0] REG_KP     = 3'd0;
  localparam logic [IDX_W-1:0] REG_KI     = 3'd1;
  localparam logic [IDX_W-1:0] REG_KD     = 3'd2;
  localparam logic [IDX_W-1:0] REG_ISTART = 3'd3;
  localparam logic [IDX_W-1:0] REG_ILIMIT = 3'd4;
  localparam logic [IDX_W-1:0] REG_DLIMIT = 3'd5;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic [GAIN_W-1:0] kd_gain;
    logic [GAIN_W-1:0] integral_start;
    logic [ILIM_W-1:0] integral_limit;
    logic [DLIM_W-1:0] drive_limit;
  } cfg_t;

endpackage

// ----- rtl/core/pvgis_cfg.sv -----
// Configuration register file for the PID step.
// Depends on pvgis_pkg for the register indexes and cfg_t.
module pvgis_cfg import pvgis_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain        <= '0;
      cfg.ki_gain        <= '0;
      cfg.kd_gain        <= '0;
      cfg.integral_start <= '0;
      cfg.integral_limit <= '0;
      cfg.drive_limit    <= DLIM_W'(SUM_SAT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP:     cfg.kp_gain        <= cfg_data[GAIN_W-1:0];
        REG_KI:     cfg.ki_gain        <= cfg_data[GAIN_W-1:0];
        REG_KD:     cfg.kd_gain        <= cfg_data[GAIN_W-1:0];
        REG_ISTART: cfg.integral_start <= cfg_data[GAIN_W-1:0];
        REG_ILIMIT: cfg.integral_limit <= cfg_data[ILIM_W-1:0];
        REG_DLIMIT: cfg.drive_limit    <= cfg_data[DLIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/pvgis_mul.sv -----
// Shared unsigned multiplier with a registered product.
// Depends on pvgis_pkg for operand widths.
module pvgis_mul import pvgis_pkg::*; (
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

// ----- rtl/core/pid_variable_gain_integral_separation.sv -----
// Top level of the PID step: sequencer, state and datapath around one shared multiplier.
// Depends on pvgis_pkg, pvgis_cfg and pvgis_mul.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+----------------------------------
//  s        | in        | s_tvalid/s_tready | s_tdata: setpoint, measured
//  m        | out       | m_tvalid/m_tready | m_tdata: drive
//  cfg      | in        | cfg_we            | cfg_index, cfg_data
//
// Items run their multiplies one after another through the single multiplier; the
// ramp branch, taken when |error| < 300, adds three states: reciprocal multiply,
// multiply back by 125 and the remainder check of the divide by 125. A new beat is
// taken while a result still waits on m; a stalled result holds the sequencer in its
// last state.
// Reset clears the sequencer, the stored error and the integral sum.
module pid_variable_gain_integral_separation import pvgis_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,   // [15:0] setpoint, [31:16] measured
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,   // [15:0] drive
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_ERR  = 11'b00000000010,
    S_KP   = 11'b00000000100,
    S_SC   = 11'b00000001000,
    S_RC   = 11'b00000010000,
    S_QD   = 11'b00000100000,
    S_CR   = 11'b00001000000,
    S_KI   = 11'b00010000000,
    S_KD   = 11'b00100000000,
    S_DT   = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  cfg_t cfg;
  state_t state;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  logic signed [IN_W-1:0]   sp_r, ms_r;
  logic [IN_W-1:0]          mag_r;
  logic                     err_neg;
  logic                     small_r;
  logic                     diff_neg;
  logic [ERR_W-1:0]         diff_mag;
  logic signed [PREV_W-1:0] prev_err;
  logic signed [ISUM_W-1:0] isum;
  logic [23:0]              p_mag;
  logic [23:0]              y_r;
  logic [17:0]              q_r;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  total;

  // error stage
  logic signed [ERR_W-1:0]    err;
  logic signed [ERR_W-1:0]    err_abs;
  logic signed [PREV_W-1:0]   diff;
  logic signed [PREV_W-1:0]   diff_abs;
  logic signed [ISUM_W:0]     isum_add;
  logic signed [ISUM_W:0]     ilim;
  logic signed [ISUM_W-1:0]   isum_next;
  logic [ISUM_W-1:0]          isum_abs;

  // datapath helpers
  logic [9:0]               scale;
  logic [24:0]              rem;
  logic [17:0]              q_fix;
  logic [31:0]              i_mag;
  logic [24:0]              d_mag;
  logic signed [ACC_W-1:0]  p_s, i_s, d_s;
  logic [DLIM_W-1:0]        eff_lim;
  logic signed [ACC_W-1:0]  olim;
  logic [OUT_W-1:0]         drive;
  logic                     out_free;

  pvgis_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pvgis_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    err      = ERR_W'(sp_r) - ERR_W'(ms_r);
    err_abs  = err[ERR_W-1] ? -err : err;
    diff     = PREV_W'(err) - prev_err;
    diff_abs = diff[PREV_W-1] ? -diff : diff;
    if ({1'b0, err_abs[IN_W-1:0]} < {1'b0, cfg.integral_start}) begin
      isum_add = (ISUM_W+1)'(isum) + (ISUM_W+1)'(err);
    end else begin
      isum_add = (ISUM_W+1)'(isum);
    end
    ilim = $signed({2'b00, cfg.integral_limit});
    priority if (isum_add > ilim) begin
      isum_next = ilim[ISUM_W-1:0];
    end else if (isum_add < -ilim) begin
      isum_next = ISUM_W'(-ilim);
    end else begin
      isum_next = isum_add[ISUM_W-1:0];
    end
    isum_abs = isum[ISUM_W-1] ? ISUM_W'(-isum) : ISUM_W'(isum);
  end

  always_comb begin
    scale = 10'(RAMP_BASE) + mag_r[9:0];
    rem   = {1'b0, y_r} - prod[24:0];
    q_fix = (rem >= 25'(DIV_CONST)) ? q_r + 18'd1 : q_r;
    i_mag = prod[GAIN_FRAC_BITS +: 32];
    d_mag = prod[GAIN_FRAC_BITS +: 25];
    p_s   = $signed({{(ACC_W-24){1'b0}}, p_mag});
    i_s   = $signed({{(ACC_W-32){1'b0}}, i_mag});
    d_s   = $signed({{(ACC_W-25){1'b0}}, d_mag});
    eff_lim = (cfg.drive_limit > DLIM_W'(SUM_SAT)) ? DLIM_W'(SUM_SAT) : cfg.drive_limit;
    olim    = $signed({{(ACC_W-DLIM_W){1'b0}}, eff_lim});
    priority if (total > olim) begin
      drive = OUT_W'(olim);
    end else if (total < -olim) begin
      drive = OUT_W'(-olim);
    end else begin
      drive = total[OUT_W-1:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_KP: begin
        mul_a = MUL_A_W'(mag_r);
        mul_b = cfg.kp_gain;
      end
      S_SC: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(scale);
      end
      S_RC: begin
        mul_a = MUL_A_W'(prod[RC_SHIFT +: 24]);
        mul_b = MUL_B_W'(RECIP);
      end
      S_QD: begin
        mul_a = MUL_A_W'(prod[RECIP_SH +: 18]);
        mul_b = MUL_B_W'(DIV_CONST);
      end
      S_KI: begin
        mul_a = MUL_A_W'(isum_abs);
        mul_b = cfg.ki_gain;
      end
      S_KD: begin
        mul_a = MUL_A_W'(diff_mag);
        mul_b = cfg.kd_gain;
      end
      S_IDLE, S_ERR, S_CR, S_DT, S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      prev_err <= '0;
      isum     <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            sp_r  <= s_tdata[15:0];
            ms_r  <= s_tdata[31:16];
            state <= S_ERR;
          end
        end
        S_ERR: begin
          mag_r    <= err_abs[IN_W-1:0];
          err_neg  <= err[ERR_W-1];
          small_r  <= (err_abs < ERR_W'(RAMP_SPAN));
          diff_neg <= diff[PREV_W-1];
          diff_mag <= diff_abs[ERR_W-1:0];
          prev_err <= PREV_W'(err);
          isum     <= isum_next;
          state    <= S_KP;
        end
        S_KP: state <= S_SC;
        S_SC: begin
          if (small_r) begin
            state <= S_RC;
          end else begin
            p_mag <= prod[GAIN_FRAC_BITS +: 24];
            state <= S_KI;
          end
        end
        S_RC: begin
          y_r   <= prod[RC_SHIFT +: 24];
          state <= S_QD;
        end
        S_QD: begin
          q_r   <= prod[RECIP_SH +: 18];
          state <= S_CR;
        end
        S_CR: begin
          p_mag <= 24'(q_fix);
          state <= S_KI;
        end
        S_KI: state <= S_KD;
        S_KD: begin
          acc   <= (err_neg ? -p_s : p_s) + (isum[ISUM_W-1] ? -i_s : i_s);
          state <= S_DT;
        end
        S_DT: begin
          total <= acc + (diff_neg ? -d_s : d_s);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= drive;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
